// ----- rtl/tfn_pkg.sv -----
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths, command codes and handshake structs for the face normal unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_BITS = 24;
    localparam int INDEX_BITS = 24;
    localparam int NORM_BITS  = 16;
    localparam int Q_SHIFT    = 14;
    localparam int CNT_BITS   = 16;

    // edge, cross term, magnitude, multiplier operand
    localparam int EW  = COORD_BITS + 1;
    localparam int CW  = 2 * COORD_BITS + 2;
    localparam int MW  = 2 * COORD_BITS + 1;
    localparam int PW  = EW + 1;
    // magnitude split for squaring
    localparam int LW  = EW;
    localparam int HW  = MW - LW;
    // sum of squares, root, root remainder, divider remainder, quotient
    localparam int SW  = 2 * MW + 2;
    localparam int RW  = SW / 2;
    localparam int RMW = RW + 3;
    localparam int DW  = RW + 2;
    localparam int QW  = Q_SHIFT + 1;

    localparam int DIV_STEPS = QW + 1;
    localparam int STEP_W    = $clog2(RW + 1);

    localparam int IN_RAW  = 9 * COORD_BITS + 3 * INDEX_BITS;
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW = 3 * INDEX_BITS + 3 * NORM_BITS;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_LOAD      = 3'd1;
    localparam logic [2:0] OP_CROSS     = 3'd2;
    localparam logic [2:0] OP_SQUARE    = 3'd3;
    localparam logic [2:0] OP_SQRT_INIT = 3'd4;
    localparam logic [2:0] OP_SQRT      = 3'd5;
    localparam logic [2:0] OP_DIV       = 3'd6;
    localparam logic [2:0] OP_FINISH    = 3'd7;

    typedef struct packed {
        logic [2:0]        op;
        logic [STEP_W-1:0] step;
        logic [1:0]        comp;
    } t_cmd;

    typedef struct packed {
        logic sum_zero;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/triangle_face_normal_top.sv -----
// ----------------------------------------------------------------------------
// triangle_face_normal_top
// Flat unit face normal (Q1.14) of one triangle per transfer.
// ----------------------------------------------------------------------------
//  channel   dir  signals                       contents
//  s_axis    in   tvalid/tready/tdata[287:0]    9 coords, then 3 indices
//  m_axis    out  tvalid/tready/tdata[119:0]    3 indices, 3 normal parts
//                 tuser, tlast                  degenerate, batch last
//  cfg       in   i_cfg_wr_en, i_cfg_wr_data    triangles per batch
//
//  The result is computed in cross, square, check, root and divide steps on
//  one shared multiplier, root unit and divider, plus the finish step; a zero
//  cross product skips the root and divide steps.
//  A new triangle is taken only once the previous one has left the datapath;
//  a waiting result is held in the output register while the next one loads.
//  Reset is synchronous: it sets the batch size to 1 and clears the counter.
// ----------------------------------------------------------------------------
module triangle_face_normal_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // first_x/y/z, second_x/y/z, third_x/y/z, first/second/third_index
    input  logic [tfn_pkg::IN_W-1:0]       s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_first/second/third_index, normal_x, normal_y, normal_z
    output logic [tfn_pkg::OUT_W-1:0]      m_axis_tdata,
    // degenerate
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_wr_en,
    input  logic [tfn_pkg::CNT_BITS-1:0]   i_cfg_wr_data
);
    import tfn_pkg::*;

    t_cmd                  cmd;
    t_stat                 stat;
    logic [INDEX_BITS-1:0] out_idx [3];
    logic [NORM_BITS-1:0]  out_norm [3];

    // sequencer: takes the transfer and paces the datapath
    tfn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // arithmetic, batch counter and the result register
    tfn_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_wr_en),
        .i_cfg_data  (i_cfg_wr_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_idx       (out_idx),
        .o_norm      (out_norm),
        .o_degen     (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

    // pack the result, indices in the low bits
    assign m_axis_tdata = OUT_W'({out_norm[2], out_norm[1], out_norm[0],
                                  out_idx[2], out_idx[1], out_idx[0]});

endmodule

// ----- rtl/tfn_ctrl.sv -----
// ----------------------------------------------------------------------------
// tfn_ctrl
// Sequencer: steps the shared datapath through cross, square, root, divide.
// ----------------------------------------------------------------------------
module tfn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tfn_pkg::t_stat i_stat,
    output tfn_pkg::t_cmd  o_cmd
);
    import tfn_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CROSS  = 3'd1;
    localparam logic [2:0] S_SQUARE = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_SQRT   = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_comp, n_comp;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_comp     = r_comp;
        o_cmd.op   = OP_NONE;
        o_cmd.step = r_step;
        o_cmd.comp = r_comp;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CROSS;
                    n_step   = '0;
                    n_comp   = '0;
                end
            end
            S_CROSS: begin
                o_cmd.op = OP_CROSS;
                if (r_step == STEP_W'(1)) begin
                    n_step = '0;
                    if (r_comp == 2'd2) begin
                        n_comp  = '0;
                        n_state = S_SQUARE;
                    end else begin
                        n_comp = r_comp + 2'd1;
                    end
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_SQUARE: begin
                o_cmd.op = OP_SQUARE;
                if (r_step == STEP_W'(2)) begin
                    n_step = '0;
                    if (r_comp == 2'd2) begin
                        n_comp  = '0;
                        n_state = S_CHECK;
                    end else begin
                        n_comp = r_comp + 2'd1;
                    end
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_CHECK: begin
                if (i_stat.sum_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_SQRT_INIT;
                    n_state  = S_SQRT;
                    n_step   = '0;
                end
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (r_step == STEP_W'(RW - 1)) begin
                    n_step  = '0;
                    n_comp  = '0;
                    n_state = S_DIV;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_step = '0;
                    if (r_comp == 2'd2) begin
                        n_comp  = '0;
                        n_state = S_DONE;
                    end else begin
                        n_comp = r_comp + 2'd1;
                    end
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_comp  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_comp  <= n_comp;
        end
    end

endmodule

// ----- rtl/tfn_dp.sv -----
// ----------------------------------------------------------------------------
// tfn_dp
// Datapath: shared multiplier, square-root and divider steps, result register.
// ----------------------------------------------------------------------------
module tfn_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tfn_pkg::t_cmd                     i_cmd,
    output tfn_pkg::t_stat                    o_stat,
    input  logic [tfn_pkg::IN_W-1:0]          i_in_data,
    input  logic                              i_cfg_we,
    input  logic [tfn_pkg::CNT_BITS-1:0]      i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [tfn_pkg::INDEX_BITS-1:0]    o_idx [3],
    output logic [tfn_pkg::NORM_BITS-1:0]     o_norm [3],
    output logic                              o_degen,
    output logic                              o_last
);
    import tfn_pkg::*;

    logic signed [EW-1:0]  r_e1 [3];
    logic signed [EW-1:0]  r_e2 [3];
    logic [INDEX_BITS-1:0] r_idx [3];
    logic [CW-1:0]         r_c [3];
    logic [SW-1:0]         r_acc;
    logic [SW-1:0]         r_sum;
    logic [SW-1:0]         r_rad;
    logic [RMW-1:0]        r_rem;
    logic [RW-1:0]         r_root;
    logic [DW-1:0]         r_drem;
    logic [QW-1:0]         r_q;
    logic [NORM_BITS-1:0]  r_norm [3];
    logic [CNT_BITS-1:0]   r_tri_count;
    logic [CNT_BITS-1:0]   r_tri_ctr;
    logic                  r_out_valid;
    logic [INDEX_BITS-1:0] r_out_idx [3];
    logic [NORM_BITS-1:0]  r_out_norm [3];
    logic                  r_out_degen;
    logic                  r_out_last;

    logic signed [COORD_BITS-1:0] coord [9];
    logic [CW-1:0]         c_sel;
    logic [MW-1:0]         mag_sel;
    logic signed [PW-1:0]  op_a, op_b;
    logic signed [2*PW-1:0] prod;
    logic [SW-1:0]         prod_s;
    logic [SW-1:0]         prod_u;
    logic [SW-1:0]         sq_term;
    logic [RMW-1:0]        rem_sh, trial;
    logic [DW-1:0]         div_sh, len_ext;
    logic                  div_ge;
    logic [QW-1:0]         n_q;
    logic [NORM_BITS-1:0]  q_signed;
    logic                  last;

    always_comb begin
        for (int j = 0; j < 9; j++) begin
            coord[j] = i_in_data[j*COORD_BITS +: COORD_BITS];
        end
    end

    // magnitude of the selected cross term
    assign c_sel   = r_c[i_cmd.comp];
    assign mag_sel = c_sel[CW-1] ? MW'(-c_sel) : MW'(c_sel);

    // operand select for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        if (i_cmd.op == OP_CROSS) begin
            case ({i_cmd.comp, i_cmd.step[0]})
                3'b000: begin op_a = PW'(r_e1[1]); op_b = PW'(r_e2[2]); end
                3'b001: begin op_a = PW'(r_e1[2]); op_b = PW'(r_e2[1]); end
                3'b010: begin op_a = PW'(r_e1[2]); op_b = PW'(r_e2[0]); end
                3'b011: begin op_a = PW'(r_e1[0]); op_b = PW'(r_e2[2]); end
                3'b100: begin op_a = PW'(r_e1[0]); op_b = PW'(r_e2[1]); end
                3'b101: begin op_a = PW'(r_e1[1]); op_b = PW'(r_e2[0]); end
                default: begin op_a = '0; op_b = '0; end
            endcase
        end else begin
            case (i_cmd.step[1:0])
                2'd0: begin
                    op_a = $signed({{(PW-LW){1'b0}}, mag_sel[LW-1:0]});
                    op_b = $signed({{(PW-LW){1'b0}}, mag_sel[LW-1:0]});
                end
                2'd1: begin
                    op_a = $signed({{(PW-HW){1'b0}}, mag_sel[MW-1:LW]});
                    op_b = $signed({{(PW-LW){1'b0}}, mag_sel[LW-1:0]});
                end
                default: begin
                    op_a = $signed({{(PW-HW){1'b0}}, mag_sel[MW-1:LW]});
                    op_b = $signed({{(PW-HW){1'b0}}, mag_sel[MW-1:LW]});
                end
            endcase
        end
    end

    assign prod   = op_a * op_b;
    assign prod_s = {{(SW-2*PW){prod[2*PW-1]}}, prod};
    assign prod_u = {{(SW-2*PW){1'b0}}, prod};

    always_comb begin
        case (i_cmd.step[1:0])
            2'd0:    sq_term = prod_u;
            2'd1:    sq_term = prod_u << (LW + 1);
            default: sq_term = prod_u << (2 * LW);
        endcase
    end

    // one digit of the square root per step
    assign rem_sh = {r_rem[RMW-3:0], r_rad[SW-1:SW-2]};
    assign trial  = {1'b0, r_root, 2'b01};

    // one quotient bit per step after the load step; the first of them compares without shifting
    assign len_ext  = DW'(r_root);
    assign div_sh   = (i_cmd.step == STEP_W'(1)) ? r_drem : {r_drem[DW-2:0], 1'b0};
    assign div_ge   = (div_sh >= len_ext);
    assign n_q      = {r_q[QW-2:0], div_ge};
    assign q_signed = c_sel[CW-1] ? -NORM_BITS'(n_q) : NORM_BITS'(n_q);

    assign last = ({1'b0, r_tri_ctr} + (CNT_BITS+1)'(1)) >= {1'b0, r_tri_count};

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                for (int k = 0; k < 3; k++) begin
                    r_e1[k]  <= EW'(coord[3+k]) - EW'(coord[k]);
                    r_e2[k]  <= EW'(coord[6+k]) - EW'(coord[k]);
                    r_idx[k] <= i_in_data[9*COORD_BITS + k*INDEX_BITS +: INDEX_BITS];
                end
                r_sum <= '0;
            end
            OP_CROSS: begin
                if (!i_cmd.step[0]) begin
                    r_acc <= prod_s;
                end else begin
                    r_c[i_cmd.comp] <= CW'(r_acc - prod_s);
                end
            end
            OP_SQUARE: begin
                r_sum <= r_sum + sq_term;
            end
            OP_SQRT_INIT: begin
                r_rad  <= r_sum;
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_SQRT: begin
                r_rad <= r_rad << 2;
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[RW-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[RW-2:0], 1'b0};
                end
            end
            OP_DIV: begin
                if (i_cmd.step == '0) begin
                    r_drem <= DW'(mag_sel);
                    r_q    <= '0;
                end else begin
                    r_drem <= div_ge ? div_sh - len_ext : div_sh;
                    r_q    <= n_q;
                    if (i_cmd.step == STEP_W'(DIV_STEPS - 1)) begin
                        r_norm[i_cmd.comp] <= q_signed;
                    end
                end
            end
            OP_FINISH: begin
                for (int k = 0; k < 3; k++) begin
                    r_out_idx[k]  <= r_idx[k];
                    r_out_norm[k] <= (r_sum == '0) ? '0 : r_norm[k];
                end
                r_out_degen <= (r_sum == '0);
                r_out_last  <= last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tri_count <= CNT_BITS'(1);
            r_tri_ctr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tri_count <= i_cfg_data;
            end
            if (i_cmd.op == OP_FINISH) begin
                r_out_valid <= 1'b1;
                r_tri_ctr   <= last ? '0 : r_tri_ctr + CNT_BITS'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.sum_zero = (r_sum == '0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_idx           = r_out_idx;
    assign o_norm          = r_out_norm;
    assign o_degen         = r_out_degen;
    assign o_last          = r_out_last;

endmodule
